// File: hdl/normalized_wake_convolution_unit_defines.svh
// Assertion macros shared by the wake convolution RTL.
`ifndef NORMALIZED_WAKE_CONVOLUTION_UNIT_DEFINES_SVH
`define NORMALIZED_WAKE_CONVOLUTION_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define NWC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("nwc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NWC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("nwc: next-cycle check failed");

`else

`define NWC_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define NWC_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

// File: hdl/nwc_pkg.sv
// Shared types and constants for the wake convolution unit.
`timescale 1ns / 1ps
`default_nettype none

package nwc_pkg;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 7;
  localparam int KV_W   = 24;
  localparam int SV_W   = 16;
  localparam int CHG_W  = 32;
  localparam int OIDX_W = 6;
  localparam int OFS_W  = 32;

  // Unsigned Q0.16 sample times signed Q8.16 kernel entry
  localparam int PROD_W = 40;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LD_KERNEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE   = 2'd2;

  // Per-result tag that travels with a sum into the divider
  typedef struct packed {
    logic [OIDX_W-1:0] pos;
    logic              last;
  } res_tag_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic ready;
    logic done_last;
  } div_sts_t;

endpackage

`default_nettype wire

// File: hdl/nwc_cell.sv
// One tap of the transposed convolution chain: density sample, multiply, add.
`timescale 1ns / 1ps
`default_nettype none

module nwc_cell #(
  parameter int ACC_W = 46
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              smp_we,
  input  logic        [nwc_pkg::SV_W-1:0]   smp_in,
  input  logic signed [nwc_pkg::KV_W-1:0]   x_in,
  input  logic signed [ACC_W-1:0]           s_in,
  output logic signed [ACC_W-1:0]           s_out
);
  import nwc_pkg::*;

  logic        [SV_W-1:0]   smp_r;
  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  sum_r;

  // Density sample held by this tap
  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_r <= smp_in;
    end
  end

  assign prod_full = $signed({1'b0, smp_r}) * x_in;

  // Product stage, then add the neighbor's partial sum
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_full[PROD_W-1:0];
      sum_r  <= {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} + s_in;
    end
  end

  assign s_out = sum_r;

endmodule

`default_nettype wire

// File: hdl/nwc_div.sv
// Serial restoring divider with saturation and the result output register.
`timescale 1ns / 1ps
`default_nettype none
`include "normalized_wake_convolution_unit_defines.svh"

module nwc_div #(
  parameter int ACC_W = 46
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic signed [ACC_W-1:0]            sum,
  input  logic        [nwc_pkg::CHG_W-1:0]   charge,
  input  nwc_pkg::res_tag_t                  tag,
  output nwc_pkg::div_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [nwc_pkg::OIDX_W-1:0]  out_index,
  output logic signed [nwc_pkg::OFS_W-1:0]   out_offset_value,
  output logic                               out_saturated,
  output logic                               out_charge_error,
  output logic                               out_last
);
  import nwc_pkg::*;

  localparam int CW = $clog2(ACC_W + 1);
  localparam logic [CW-1:0] STEPS = CW'(ACC_W);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0] quo_r;
  logic [CHG_W-1:0] rem_r;
  logic [CHG_W-1:0] dvs_r;
  logic             neg_r;
  logic             zero_r;
  res_tag_t         tag_r;

  logic [OIDX_W-1:0]       out_index_r;
  logic signed [OFS_W-1:0] out_offset_value_r;
  logic                    out_saturated_r;
  logic                    out_charge_error_r;
  logic                    out_last_r;

  logic [ACC_W-1:0] sum_u;
  logic [ACC_W-1:0] mag;
  logic [CHG_W:0]   rem_sh;
  logic [CHG_W:0]   rem_sub;
  logic             ge;
  logic             slot_free;
  logic             load_out;
  logic             hi_any;
  logic             sat;
  logic [OFS_W-1:0] res_val;

  // Magnitude of the signed sum
  assign sum_u = sum;
  assign mag   = sum[ACC_W-1] ? (~sum_u + ACC_W'(1)) : sum_u;

  // One quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[ACC_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // Clip quotient to signed 32 bits
  assign hi_any = |quo_r[ACC_W-1:OFS_W];
  always_comb begin
    if (neg_r) begin
      sat     = hi_any | (quo_r[OFS_W-1] & (|quo_r[OFS_W-2:0]));
      res_val = sat ? {1'b1, {(OFS_W-1){1'b0}}} : (~quo_r[OFS_W-1:0] + OFS_W'(1));
    end else begin
      sat     = hi_any | quo_r[OFS_W-1];
      res_val = sat ? {1'b0, {(OFS_W-1){1'b1}}} : quo_r[OFS_W-1:0];
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = (state_r == DV_FIN) && slot_free;

  // Divider control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      DV_IDLE: begin
        if (go) begin
          state_nxt = (charge == '0) ? DV_FIN : DV_RUN;
          cnt_nxt   = STEPS;
        end
      end
      DV_RUN: begin
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = DV_FIN;
        end
      end
      DV_FIN: begin
        if (slot_free) begin
          state_nxt = DV_IDLE;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DV_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operands and shift registers
  always_ff @(posedge clk) begin
    if (go) begin
      neg_r  <= sum[ACC_W-1];
      zero_r <= (charge == '0);
      dvs_r  <= charge;
      quo_r  <= mag;
      rem_r  <= '0;
      tag_r  <= tag;
    end else if (state_r == DV_RUN) begin
      rem_r <= ge ? rem_sub[CHG_W-1:0] : rem_sh[CHG_W-1:0];
      quo_r <= {quo_r[ACC_W-2:0], ge};
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index_r        <= tag_r.pos;
      out_last_r         <= tag_r.last;
      out_charge_error_r <= zero_r;
      out_saturated_r    <= zero_r ? 1'b0 : sat;
      out_offset_value_r <= zero_r ? '0 : res_val;
    end
  end

  assign sts.ready     = (state_r == DV_IDLE);
  assign sts.done_last = load_out && tag_r.last;

  assign out_valid        = out_valid_r;
  assign out_index        = out_index_r;
  assign out_offset_value = out_offset_value_r;
  assign out_saturated    = out_saturated_r;
  assign out_charge_error = out_charge_error_r;
  assign out_last         = out_last_r;

  `NWC_ASSERT_IMP(a_run_cnt, clk, rst_n, state_r == DV_RUN, cnt_r != '0)
  `NWC_ASSERT_IMP(a_zero_chg, clk, rst_n, out_valid_r && out_charge_error_r,
                  out_offset_value_r == '0 && !out_saturated_r)

endmodule

`default_nettype wire

// File: hdl/normalized_wake_convolution_unit.sv
// Top level: kernel memory, tap chain, compute sequencer and divider.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | cmd, index, kernel, sample, charge
//   out_    | output    | out_valid/out_stall| index, offset, saturated, error, last
//
// Load words are accepted while the sequencer is idle. A compute word streams
// kernel entries 1..2N-1 through the N-tap chain (one memory read a cycle
// unless the chain is stalled; three stages: read, product, sum), so the
// chain could offer a sum every cycle; each sum then occupies the serial
// divider, which takes no new sum until idle; zero charge skips the division.
// Reset clears control only; both stores are undefined until loaded.
// A stalled output holds the divider, which in turn freezes the chain.
`timescale 1ns / 1ps
`default_nettype none
`include "normalized_wake_convolution_unit_defines.svh"

module normalized_wake_convolution_unit #(
  parameter int MESH_SIZE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [nwc_pkg::CMD_W-1:0]   in_cmd,
  input  logic        [nwc_pkg::IDX_W-1:0]   in_index,
  input  logic signed [nwc_pkg::KV_W-1:0]    in_kernel_value,
  input  logic        [nwc_pkg::SV_W-1:0]    in_sample_value,
  input  logic        [nwc_pkg::CHG_W-1:0]   in_charge_total,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [nwc_pkg::OIDX_W-1:0]  out_index,
  output logic signed [nwc_pkg::OFS_W-1:0]   out_offset_value,
  output logic                               out_saturated,
  output logic                               out_charge_error,
  output logic                               out_last
);
  import nwc_pkg::*;

  localparam int NW     = $clog2(MESH_SIZE);
  localparam int KW     = NW + 1;
  localparam int ACC_W  = PROD_W + NW;
  localparam int KDEPTH = 2 * MESH_SIZE;

  localparam logic [IDX_W:0]  K_LIM    = (IDX_W+1)'(KDEPTH);
  localparam logic [KW-1:0]   N_LIM    = KW'(MESH_SIZE);
  localparam logic [KW-1:0]   ADDR_END = KW'(KDEPTH - 1);
  localparam logic [NW-1:0]   POS_END  = NW'(MESH_SIZE - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STREAM = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [KW-1:0] addr_r, addr_nxt;
  logic          iss_r, iss_nxt;
  logic [2:0]    tg_r, tg_nxt;
  logic [NW-1:0] pos_r, pos_nxt;
  logic [CHG_W-1:0] charge_r;

  logic signed [KV_W-1:0] kmem [KDEPTH];
  logic signed [KV_W-1:0] rd_r;

  logic              in_acc;
  logic              kmem_we;
  logic              chain_en;
  logic              div_go;
  div_sts_t          div_sts;
  res_tag_t          div_tag;
  logic [MESH_SIZE-1:0]   smp_we;
  logic signed [ACC_W-1:0] s_w [MESH_SIZE+1];

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign kmem_we  = in_acc && (in_cmd == CMD_LD_KERNEL) && ({1'b0, in_index} < K_LIM);

  // Kernel memory: one write port, registered read into the chain
  always_ff @(posedge clk) begin
    if (kmem_we) begin
      kmem[in_index[KW-1:0]] <= in_kernel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_en) begin
      rd_r <= kmem[addr_r];
    end
  end

  // Chain advances while streaming unless a finished sum waits for the divider
  assign chain_en = (state_r == ST_STREAM) && !(tg_r[2] && !div_sts.ready);
  assign div_go   = (state_r == ST_STREAM) && tg_r[2] && div_sts.ready;

  // Compute sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    iss_nxt   = iss_r;
    tg_nxt    = tg_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_COMPUTE)) begin
          state_nxt = ST_STREAM;
          addr_nxt  = KW'(1);
          iss_nxt   = 1'b1;
          tg_nxt    = '0;
          pos_nxt   = '0;
        end
      end
      ST_STREAM: begin
        if (chain_en) begin
          tg_nxt = {tg_r[1:0], iss_r && (addr_r >= N_LIM)};
          if (iss_r) begin
            addr_nxt = addr_r + KW'(1);
            if (addr_r == ADDR_END) begin
              iss_nxt = 1'b0;
            end
          end
        end
        if (div_go) begin
          pos_nxt = pos_r + NW'(1);
          if (pos_r == POS_END) begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (div_sts.done_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
      iss_r   <= 1'b0;
      tg_r    <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      iss_r   <= iss_nxt;
      tg_r    <= tg_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Charge held for the whole run
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_COMPUTE)) begin
      charge_r <= in_charge_total;
    end
  end

  // Tap chain: partial sums flow toward tap 0
  assign s_w[MESH_SIZE] = '0;

  for (genvar j = 0; j < MESH_SIZE; j++) begin : g_tap
    assign smp_we[j] = in_acc && (in_cmd == CMD_LD_SAMPLE) && (in_index == IDX_W'(j));

    nwc_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk    (clk),
      .en     (chain_en),
      .smp_we (smp_we[j]),
      .smp_in (in_sample_value),
      .x_in   (rd_r),
      .s_in   (s_w[j+1]),
      .s_out  (s_w[j])
    );
  end

  // Divider and output register
  assign div_tag.pos  = OIDX_W'(pos_r);
  assign div_tag.last = (pos_r == POS_END);

  nwc_div #(
    .ACC_W (ACC_W)
  ) u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .go               (div_go),
    .sum              (s_w[0]),
    .charge           (charge_r),
    .tag              (div_tag),
    .sts              (div_sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index        (out_index),
    .out_offset_value (out_offset_value),
    .out_saturated    (out_saturated),
    .out_charge_error (out_charge_error),
    .out_last         (out_last)
  );

  `NWC_ASSERT_IMP(a_wait_drained, clk, rst_n, state_r == ST_WAIT, tg_r == '0 && !iss_r)
  `NWC_ASSERT_NXT(a_run_start, clk, rst_n, in_acc && (in_cmd == CMD_COMPUTE),
                  state_r == ST_STREAM && pos_r == '0 && iss_r)

endmodule

`default_nettype wire

// File: bench/tb.sv
// Testbench for the normalized wake convolution unit: table-driven and random words.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import nwc_pkg::*;

  localparam int N = 64;
  // Random load/compute words per idling phase (ignored words not counted)
  localparam int RAND_WORDS_PER_PHASE = 80;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One input word, plus an optional typed expectation shared by all N offsets
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [KV_W-1:0]  kv;
    logic [SV_W-1:0]  sv;
    logic [CHG_W-1:0] chg;
    logic             typed;
    logic [OFS_W-1:0] ofs;
    logic             sat;
    logic             err;
  } in_word_t;

  // One offset word as it should leave the block
  typedef struct packed {
    logic [OIDX_W-1:0] pos;
    logic [OFS_W-1:0]  ofs;
    logic              sat;
    logic              err;
    logic              last;
  } offset_word_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [IDX_W-1:0] in_index = '0;
  logic signed [KV_W-1:0] in_kernel_value = '0;
  logic [SV_W-1:0] in_sample_value = '0;
  logic [CHG_W-1:0] in_charge_total = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OIDX_W-1:0] out_index;
  logic signed [OFS_W-1:0] out_offset_value;
  logic out_saturated;
  logic out_charge_error;
  logic out_last;

  // Shadow stores and pending offsets
  logic signed [KV_W-1:0] kernel_mem [0:2*N-1];
  logic [SV_W-1:0] density_mem [0:N-1];
  offset_word_t offsets_q [$];
  in_word_t word_table [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int mismatches = 0;
  offset_word_t exp_w;

  normalized_wake_convolution_unit #(.MESH_SIZE(N)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_index(in_index),
    .in_kernel_value(in_kernel_value),
    .in_sample_value(in_sample_value),
    .in_charge_total(in_charge_total),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_index(out_index),
    .out_offset_value(out_offset_value),
    .out_saturated(out_saturated),
    .out_charge_error(out_charge_error),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one expected offset word at the tail
  function automatic void queue_offset(input offset_word_t w);
    offsets_q.insert(offsets_q.size(), w);
  endfunction

  // Append one row to the stimulus table
  function automatic void add_row(input in_word_t w);
    word_table.insert(word_table.size(), w);
  endfunction

  // Exact convolution sum, one truncating divide, signed 32-bit clamp
  function automatic void predict_offsets(input logic [CHG_W-1:0] chg);
    offset_word_t w;
    longint acc;
    longint unsigned mag;
    longint unsigned quo;
    for (int i = 0; i < N; i++) begin
      w = '0;
      w.pos = OIDX_W'(i);
      w.last = (i == N - 1);
      if (chg == '0) begin
        w.err = 1'b1;
      end else begin
        acc = 0;
        for (int j = 0; j < N; j++)
          acc += longint'(density_mem[j]) * longint'(kernel_mem[N + i - j]);
        mag = (acc < 0) ? 64'd0 - acc : acc;
        quo = mag / {32'd0, chg};
        if (acc < 0) begin
          if (quo > 64'h8000_0000) begin
            quo = 64'h8000_0000;
            w.sat = 1'b1;
          end
          quo = 64'd0 - quo;
        end else if (quo > 64'h7FFF_FFFF) begin
          quo = 64'h7FFF_FFFF;
          w.sat = 1'b1;
        end
        w.ofs = quo[OFS_W-1:0];
      end
      queue_offset(w);
    end
  endfunction

  // Update the shadow stores or queue the offsets a word calls for
  function automatic void apply_word(input in_word_t w);
    offset_word_t e;
    case (w.cmd)
      CMD_LD_KERNEL: begin
        if (w.idx < 2 * N) kernel_mem[w.idx] = w.kv;
      end
      CMD_LD_SAMPLE: begin
        if (w.idx < N) density_mem[w.idx[OIDX_W-1:0]] = w.sv;
      end
      CMD_COMPUTE: begin
        if (w.typed) begin
          for (int i = 0; i < N; i++) begin
            e.pos = OIDX_W'(i);
            e.ofs = w.ofs;
            e.sat = w.sat;
            e.err = w.err;
            e.last = (i == N - 1);
            queue_offset(e);
          end
        end else begin
          predict_offsets(w.chg);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_word_t make_word(input logic [CMD_W-1:0] cmd,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [KV_W-1:0] kv,
                                         input logic [SV_W-1:0] sv,
                                         input logic [CHG_W-1:0] chg,
                                         input logic typed,
                                         input logic [OFS_W-1:0] ofs,
                                         input logic sat,
                                         input logic err);
    in_word_t w;
    w.cmd = cmd;
    w.idx = idx;
    w.kv = kv;
    w.sv = sv;
    w.chg = chg;
    w.typed = typed;
    w.ofs = ofs;
    w.sat = sat;
    w.err = err;
    return w;
  endfunction

  // Random word: mostly loads, some computes, a little noise
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    int sel;
    w = '0;
    w.idx = IDX_W'($urandom);
    w.kv = KV_W'($urandom);
    w.sv = SV_W'($urandom);
    w.chg = $urandom;
    pick = $urandom_range(99);
    sel = $urandom_range(19);
    if (pick < 45) begin
      w.cmd = CMD_LD_KERNEL;
      if (sel == 0) w.kv = 24'h7F_FFFF;
      else if (sel == 1) w.kv = 24'h80_0000;
      else if (sel == 2) w.kv = '0;
    end else if (pick < 88) begin
      w.cmd = CMD_LD_SAMPLE;
      if (sel < 17) w.idx = IDX_W'($urandom_range(N - 1));
      if (sel == 0 || sel == 17) w.sv = 16'hFFFF;
      else if (sel == 1 || sel == 18) w.sv = '0;
    end else if (pick < 95) begin
      w.cmd = CMD_COMPUTE;
      if (sel < 3) w.chg = '0;
      else if (sel < 7) w.chg = $urandom_range(255, 1);
      else if (sel == 11) w.chg = 32'hFFFF_FFFF;
      else if (sel > 11) w.chg = $urandom_range(32'hFFFF_FFFF, 32'h1000_0000);
    end else begin
      w.cmd = CMD_UNUSED;
    end
    return w;
  endfunction

  // Present one word at the falling edge, hold it until taken
  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= w.cmd;
    in_index <= w.idx;
    in_kernel_value <= w.kv;
    in_sample_value <= w.sv;
    in_charge_total <= w.chg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_word(w);
    @(negedge clk);
  endtask

  // Hold off new words until every pending offset has come back
  task automatic drain_offsets();
    in_valid <= 1'b0;
    @(negedge clk);
    while (offsets_q.size() != 0) @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // Compare each taken offset word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (offsets_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected offset word, index %0d value %0d", out_index,
                   out_offset_value);
      end else begin
        exp_w = offsets_q.pop_front();
        if (out_index !== exp_w.pos || out_offset_value !== exp_w.ofs ||
            out_saturated !== exp_w.sat || out_charge_error !== exp_w.err ||
            out_last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch exp %0d %0d %b %b %b / got %0d %0d %b %b %b",
                     exp_w.pos, $signed(exp_w.ofs), exp_w.sat, exp_w.err, exp_w.last,
                     out_index, out_offset_value, out_saturated, out_charge_error,
                     out_last);
        end
      end
    end
  end

  // Main sequence
  initial begin
    int useful;
    in_word_t w;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every entry a compute reads: kernel at its minimum, density at full scale
    for (int k = 0; k < 2 * N; k++)
      add_row(make_word(CMD_LD_KERNEL, IDX_W'(k), 24'h80_0000, '0, '0,
                        1'b0, '0, 1'b0, 1'b0));
    for (int d = 0; d < N; d++)
      add_row(make_word(CMD_LD_SAMPLE, IDX_W'(d), '0, 16'hFFFF, '0,
                        1'b0, '0, 1'b0, 1'b0));
    // Unit charge on the most negative sum clamps everywhere
    add_row(make_word(CMD_COMPUTE, '0, '0, '0, 32'd1,
                      1'b1, 32'h8000_0000, 1'b1, 1'b0));
    // Zero charge: offsets forced to zero with the error flag
    add_row(make_word(CMD_COMPUTE, '0, '0, '0, 32'd0,
                      1'b1, '0, 1'b0, 1'b1));
    // Largest charge, quotient truncated toward zero
    add_row(make_word(CMD_COMPUTE, '0, '0, '0, 32'hFFFF_FFFF,
                      1'b0, '0, 1'b0, 1'b0));
    // Out-of-range density indexes and the unused command change nothing
    add_row(make_word(CMD_LD_SAMPLE, 7'd64, '0, 16'h0000, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_LD_SAMPLE, 7'd127, 24'hFF_FFFF, 16'h0000,
                      32'hFFFF_FFFF, 1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_UNUSED, 7'd0, 24'h7F_FFFF, 16'h0000, 32'd0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_COMPUTE, '0, '0, '0, 32'd1,
                      1'b1, 32'h8000_0000, 1'b1, 1'b0));
    // Kernel and density extremes at the edges of both stores
    add_row(make_word(CMD_LD_KERNEL, 7'd127, 24'h7F_FFFF, '0, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_LD_KERNEL, 7'd64, 24'h7F_FFFF, '0, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_LD_KERNEL, 7'd0, 24'h7F_FFFF, '0, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_LD_SAMPLE, 7'd0, '0, 16'h0000, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_LD_SAMPLE, 7'd63, '0, 16'h8000, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_COMPUTE, '0, '0, '0, 32'h8000_0000,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_COMPUTE, '0, '0, '0, 32'd3,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_LD_SAMPLE, 7'd32, '0, 16'h0001, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_LD_KERNEL, 7'd1, 24'h00_0001, '0, '0,
                      1'b0, '0, 1'b0, 1'b0));
    add_row(make_word(CMD_COMPUTE, '0, '0, '0, 32'h0001_0000,
                      1'b0, '0, 1'b0, 1'b0));

    // Sender idles lightly, receiver heavily
    snd_idle_pct = 22;
    rcv_idle_pct = 74;
    foreach (word_table[r]) send_word(word_table[r]);
    drain_offsets();

    // Random words in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        snd_idle_pct = 74;
        rcv_idle_pct = 22;
      end else if (ph == 2) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      useful = 0;
      while (useful < RAND_WORDS_PER_PHASE) begin
        w = random_word();
        send_word(w);
        if (!(w.cmd == CMD_UNUSED || (w.cmd == CMD_LD_SAMPLE && w.idx >= N))) useful++;
      end
      drain_offsets();
    end

    // Trailing window for stray output words
    repeat (200) @(negedge clk);
    mismatches += offsets_q.size();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
